// ===== rtl/cpsr_pkg.sv =====
// Shared constants, types and helpers of the clipped span rasterizer.
package cpsr_pkg;

    // Screen and coordinate format
    localparam int SCREEN_COLUMNS      = 320;
    localparam int SCREEN_ROWS         = 240;
    localparam int COORD_FRACTION_BITS = 4;

    // Rounded column width: a signed 16-bit coordinate loses its fraction bits
    localparam int COL_W     = 17 - COORD_FRACTION_BITS;
    localparam int OFF_W     = COL_W + 1;
    localparam int PROD_W    = 32 + OFF_W + 1;
    localparam int Y0_SHIFT  = 16 - COORD_FRACTION_BITS;
    localparam int HALF_COORD = (1 << COORD_FRACTION_BITS) >> 1;

    // Slope divider: quotient bits, one per cycle
    localparam int DIV_W   = 34;
    localparam int DEN_W   = 18;
    localparam int DCNT_W  = 6;

    // Stream widths
    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 64;

    // Edge order in the state arrays
    localparam logic [1:0] EDGE_TOP      = 2'd0;
    localparam logic [1:0] EDGE_BOTTOM   = 2'd1;
    localparam logic [1:0] EDGE_CLIP_TOP = 2'd2;
    localparam logic [1:0] EDGE_LAST     = 2'd3;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Controller states
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ADV   = 8'b0000_0010,
        S_OUT   = 8'b0000_0100,
        S_DINIT = 8'b0000_1000,
        S_DRUN  = 8'b0001_0000,
        S_SLOPE = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_ACC   = 8'b1000_0000
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       div_init;
        logic       div_step;
        logic       slope_wr;
        logic       mul;
        logic       acc_wr;
        logic       advance;
        logic       out_wr;
        logic [1:0] idx;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic none_left;
        logic div_done;
        logic out_free;
    } t_stat;

    // Round a signed coordinate to a whole column, half away from zero
    function automatic logic signed [COL_W-1:0] round_coord(input logic [15:0] v);
        logic signed [16:0] ve;
        logic [16:0]        mag;
        logic [16:0]        r;
        ve  = {v[15], v};
        mag = ve[16] ? 17'(-ve) : 17'(ve);
        r   = (mag + 17'(HALF_COORD)) >> COORD_FRACTION_BITS;
        return ve[16] ? COL_W'(-r) : COL_W'(r);
    endfunction

endpackage

// ===== rtl/cpsr_dp.sv =====
// Datapath: edge setup, slope divider, edge accumulators and span output register.
module cpsr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cpsr_pkg::t_cmd                  i_cmd,
    output cpsr_pkg::t_stat                 o_stat,
    input  logic [cpsr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [cpsr_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                            o_m_tuser,
    output logic                            o_m_tlast
);
    import cpsr_pkg::*;

    // Held primitive
    logic [63:0]             r_edge [4];
    logic [15:0]             r_color;
    logic                    r_shade;
    logic signed [COL_W-1:0] r_first, r_end, r_cur, r_pmin, r_cmin;
    logic [OFF_W-1:0]        r_offp, r_offc;
    logic signed [31:0]      r_slope [4];
    logic signed [31:0]      r_acc   [4];
    // Divider
    logic [DIV_W-1:0]        r_num;
    logic [DEN_W-1:0]        r_rem, r_den;
    logic [DCNT_W-1:0]       r_cnt;
    logic                    r_neg, r_dxz;
    logic signed [PROD_W-1:0] r_prod;
    // Output register
    logic                    r_ovalid;
    logic [OUT_DATA_W-1:0]   r_odata;
    logic                    r_ouser, r_olast;

    logic signed [COL_W-1:0] w_pmin, w_pmax, w_cmin, w_cmax;
    logic [63:0]             w_e;
    logic signed [16:0]      w_dx, w_dy;
    logic [16:0]             w_adx, w_ady;
    logic [DEN_W:0]          w_shift;
    logic [DEN_W:0]          w_diff;
    logic [31:0]             w_qs;
    logic signed [PROD_W:0]  w_sum;
    logic signed [31:0]      w_start;
    logic signed [32:0]      w_adv [4];
    logic signed [31:0]      w_top, w_bot;
    logic [16:0]             w_rtop, w_rbot;
    logic signed [COL_W:0]   w_xn;
    logic                    w_last, w_onscr, w_edgecol;
    logic [OUT_DATA_W-1:0]   w_odata;
    logic [15:0]             w_body, w_fcol;

    // Column rounding straight from the incoming item
    assign w_pmin = round_coord(i_s_tdata[15:0]);
    assign w_pmax = round_coord(i_s_tdata[47:32]);
    assign w_cmin = round_coord(i_s_tdata[143:128]);
    assign w_cmax = round_coord(i_s_tdata[175:160]);

    // Edge deltas of the selected edge
    assign w_e   = r_edge[i_cmd.idx];
    assign w_dx  = 17'(signed'(w_e[47:32])) - 17'(signed'(w_e[15:0]));
    assign w_dy  = 17'(signed'(w_e[63:48])) - 17'(signed'(w_e[31:16]));
    assign w_adx = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
    assign w_ady = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);

    // Restoring divider step
    assign w_shift = {r_rem, r_num[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    // Quotient saturated to the positive int32 range
    assign w_qs = (r_num[DIV_W-1:31] != '0) ? 32'h7FFF_FFFF : r_num[31:0];

    // Start value: y0 scaled plus slope times offset
    assign w_sum = (PROD_W+1)'(signed'(w_e[31:16])) * (PROD_W+1)'(1 << Y0_SHIFT)
                 + (PROD_W+1)'(r_prod);
    always_comb begin
        if (w_sum > (PROD_W+1)'(33'sh0_7FFF_FFFF)) begin
            w_start = 32'sh7FFF_FFFF;
        end else if (w_sum < -(PROD_W+1)'(33'sh0_8000_0000)) begin
            w_start = 32'sh8000_0000;
        end else begin
            w_start = 32'(w_sum);
        end
    end

    // Saturating edge advance
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_adv[i] = 33'(r_acc[i]) + 33'(r_slope[i]);
        end
    end

    // Span rows from the registered accumulators
    assign w_top  = (r_acc[0] > r_acc[2]) ? r_acc[0] : r_acc[2];
    assign w_bot  = (r_acc[1] < r_acc[3]) ? r_acc[1] : r_acc[3];
    assign w_rtop = 17'(({1'b0, w_top} + 33'h0_0000_8000) >> 16);
    assign w_rbot = 17'(({1'b0, w_bot} + 33'h0_0000_8000) >> 16);

    assign w_xn      = (COL_W+1)'(r_cur) + (COL_W+1)'(1);
    assign w_last    = w_xn >= (COL_W+1)'(r_end);
    assign w_onscr   = !r_cur[COL_W-1] && (32'(r_cur) < 32'(SCREEN_COLUMNS));
    assign w_edgecol = (r_cur == r_first) || (w_xn == (COL_W+1)'(r_end));
    assign w_body    = (r_shade && w_edgecol) ? 16'h0000 : r_color;
    assign w_fcol    = r_shade ? 16'h0000 : r_color;

    function automatic logic [7:0] clamp_row(input logic [31:0] a, input logic [16:0] r);
        if (a[31]) begin
            return 8'd0;
        end else if (r > 17'(SCREEN_ROWS)) begin
            return 8'(SCREEN_ROWS);
        end else begin
            return r[7:0];
        end
    endfunction

    assign w_odata = {7'd0, w_fcol, w_body, clamp_row(w_bot, w_rbot),
                      clamp_row(w_top, w_rtop), 9'(r_cur)};

    // Status
    assign o_stat.none_left = r_cur >= r_end;
    assign o_stat.div_done  = (r_cnt == '0);
    assign o_stat.out_free  = !r_ovalid || i_m_tready;

    // Primitive setup and edge state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_end   <= '0;
            r_cur   <= '0;
            r_color <= '0;
            r_shade <= 1'b0;
            r_cnt   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_acc[i]   <= '0;
                r_slope[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_edge[0] <= i_s_tdata[63:0];
                r_edge[1] <= i_s_tdata[127:64];
                r_edge[2] <= i_s_tdata[191:128];
                r_edge[3] <= i_s_tdata[255:192];
                r_color   <= i_s_tdata[271:256];
                r_shade   <= i_s_tdata[272];
                r_pmin    <= w_pmin;
                r_cmin    <= w_cmin;
                r_first   <= (w_pmin > w_cmin) ? w_pmin : w_cmin;
                r_end     <= (w_pmax < w_cmax) ? w_pmax : w_cmax;
                r_cur     <= (w_pmin > w_cmin) ? w_pmin : w_cmin;
            end
            // Divider load
            if (i_cmd.div_init) begin
                r_offp <= OFF_W'((COL_W+1)'(r_first) - (COL_W+1)'(r_pmin));
                r_offc <= OFF_W'((COL_W+1)'(r_first) - (COL_W+1)'(r_cmin));
                r_num  <= DIV_W'({w_ady[15:0], 17'd0}) + DIV_W'(w_adx);
                r_den  <= DEN_W'({w_adx, 1'b0});
                r_rem  <= '0;
                r_cnt  <= DCNT_W'(DIV_W);
                r_neg  <= w_dx[16] != w_dy[16];
                r_dxz  <= (w_dx == '0);
            end
            // One quotient bit per cycle
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt - 1'b1;
                if (!w_diff[DEN_W]) begin
                    r_rem <= w_diff[DEN_W-1:0];
                    r_num <= {r_num[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[DEN_W-1:0];
                    r_num <= {r_num[DIV_W-2:0], 1'b0};
                end
            end
            if (i_cmd.slope_wr) begin
                r_slope[i_cmd.idx] <= r_dxz ? 32'sd0 : (r_neg ? -signed'(w_qs) : signed'(w_qs));
            end
            if (i_cmd.acc_wr) begin
                r_acc[i_cmd.idx] <= w_start;
            end
            if (i_cmd.advance) begin
                for (int i = 0; i < 4; i++) begin
                    if (w_adv[i][32] != w_adv[i][31]) begin
                        r_acc[i] <= w_adv[i][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end else begin
                        r_acc[i] <= w_adv[i][31:0];
                    end
                end
            end
            if (i_cmd.out_wr && !o_stat.none_left) begin
                r_cur <= COL_W'(w_xn);
            end
        end
    end

    // Slope times start offset
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_slope[i_cmd.idx])
                    * PROD_W'(signed'({1'b0, (i_cmd.idx < EDGE_CLIP_TOP) ? r_offp : r_offc}));
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_wr) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            if (o_stat.none_left) begin
                r_odata <= '0;
                r_ouser <= 1'b0;
                r_olast <= 1'b1;
            end else begin
                r_odata <= w_onscr ? w_odata : '0;
                r_ouser <= w_onscr;
                r_olast <= w_last;
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign o_m_tlast  = r_olast;

    // The output register is never overwritten while a result waits
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_wr |-> (!r_ovalid || i_m_tready))
        else $error("output overwritten");
    // Writing a result always presents it in the next cycle
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_wr |=> r_ovalid)
        else $error("result not presented");
    // The divider only steps while bits remain
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_cnt != '0))
        else $error("divider overrun");

endmodule

// ===== rtl/cpsr_ctrl.sv =====
// Controller: sequences column steps and the per-edge primitive setup (top, bottom, clip top, clip bottom).
module cpsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  logic            i_s_tuser,
    input  cpsr_pkg::t_stat i_stat,
    output cpsr_pkg::t_cmd  o_cmd
);
    import cpsr_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic       w_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_s_tuser == CMD_START) begin
                        o_cmd.load = 1'b1;
                        n_idx      = EDGE_TOP;
                        n_state    = S_DINIT;
                    end else begin
                        n_state = S_ADV;
                    end
                end
            end
            S_ADV: begin
                o_cmd.advance = !i_stat.none_left;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_wr = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DRUN;
            end
            S_DRUN: begin
                if (i_stat.div_done) begin
                    n_state = S_SLOPE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SLOPE: begin
                o_cmd.slope_wr = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_wr = 1'b1;
                n_idx        = r_idx + 1'b1;
                n_state      = (r_idx == EDGE_LAST) ? S_IDLE : S_DINIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= EDGE_TOP;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // An accepted item always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != S_IDLE))
        else $error("item accepted without work");
    // A finished division goes to the slope write
    a_div_slope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRUN && i_stat.div_done) |=> (r_state == S_SLOPE))
        else $error("division result skipped");
    // Setup leaves to idle only after the last edge
    a_setup_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC && r_idx != EDGE_LAST) |=> (r_state == S_DINIT))
        else $error("edge setup cut short");

endmodule

// ===== rtl/clipped_parallelogram_span_rasterizer_unit.sv =====
// Top level of the clipped parallelogram column-span rasterizer.
//
// Input channel (i_s_*): one item is a start (tuser = 0) or a step (tuser = 1).
// A start carries the wall parallelogram, the clip window, the fill color and
// the shading flag; it yields no result. Each step yields exactly one span
// item on the output channel (o_m_*) for the next column of the primitive,
// with tuser flagging a span on screen and tlast marking the final column.
// A step is accepted when the unit is idle; the advance state then moves all
// edge accumulators on and the output state loads the output register as
// soon as it is free, which presents the span. For a start, the shared
// one-bit-per-cycle slope divider is loaded, yields 34 quotient bits and is
// checked for done for each edge in turn, followed by the slope, multiply
// and accumulator writes for that edge.
// The unit takes the next item while a finished span waits in the output
// register; a step whose span cannot be stored waits until the receiver takes
// the previous one, so a stalled receiver holds back the input channel.
// Reset (synchronous, active low) clears all edge state, so a step right after
// reset returns an empty item with tlast set.
module clipped_parallelogram_span_rasterizer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // top_edge, bottom_edge, clip_top_edge, clip_bottom_edge, fill_color,
    // shading_on, zero fill
    input  logic [cpsr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // cmd
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // column_x, span_first_y, span_end_y, body_color, first_pixel_color, zero fill
    output logic [cpsr_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // span_valid
    output logic                            o_m_tuser,
    // last_column
    output logic                            o_m_tlast
);
    import cpsr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    cpsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cpsr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== tb/sv/span_checker.sv =====
// Span checker: predicts every span item of the rasterizer and compares.
`timescale 1ns / 100ps

module span_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // top_edge, bottom_edge, clip_top_edge, clip_bottom_edge, fill_color,
    // shading_on, zero fill
    input  logic [cpsr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // cmd
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // column_x, span_first_y, span_end_y, body_color, first_pixel_color, zero fill
    input  logic [cpsr_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // span_valid
    input  logic                            i_m_tuser,
    // last_column
    input  logic                            i_m_tlast,
    output int                              o_fail_count,
    output int                              o_pending
);
    import cpsr_pkg::*;

    typedef struct packed {
        logic [8:0]  column_x;
        logic [7:0]  first_y;
        logic [7:0]  end_y;
        logic [15:0] body_color;
        logic [15:0] first_color;
        logic        on_screen;
        logic        last_col;
    } t_span;

    t_span span_queue[$];

    // Predictor state
    int          acc[4];
    int          slope[4];
    int          cur_col, first_col, end_col;
    logic [15:0] color_q;
    logic        shade_q;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    function automatic int sat32(longint v);
        if (v > I32_MAX) return int'(I32_MAX);
        if (v < I32_MIN) return int'(I32_MIN);
        return int'(v);
    endfunction

    // Round half away from zero
    function automatic longint round_half(longint v, int fb);
        longint mag, r;
        mag = (v < 0) ? -v : v;
        r   = (mag + ((64'sd1 << fb) >>> 1)) >>> fb;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint coord(logic [63:0] e, int s);
        logic signed [15:0] c;
        c = e[s*16 +: 16];
        return longint'(c);
    endfunction

    function automatic int edge_slope(logic [63:0] e);
        longint dx, dy, n, d, q;
        dx = coord(e, 2) - coord(e, 0);
        dy = coord(e, 3) - coord(e, 1);
        if (dx == 0) return 0;
        n = ((dy < 0) ? -dy : dy) * 65536;
        d = (dx < 0) ? -dx : dx;
        q = (2 * n + d) / (2 * d);
        if (q > I32_MAX) q = I32_MAX;
        return ((dx < 0) != (dy < 0)) ? int'(-q) : int'(q);
    endfunction

    function automatic logic [7:0] row_of(int a);
        longint r;
        r = round_half(longint'(a), 16);
        if (r < 0) return 8'd0;
        if (r > SCREEN_ROWS) return 8'(SCREEN_ROWS);
        return 8'(r);
    endfunction

    // Load a new primitive
    task automatic load_primitive(logic [IN_DATA_W-1:0] d);
        logic [63:0] e[4];
        int pmin, pmax, cmin, cmax, off;
        for (int i = 0; i < 4; i++) e[i] = d[i*64 +: 64];
        pmin = int'(round_half(coord(e[0], 0), COORD_FRACTION_BITS));
        pmax = int'(round_half(coord(e[0], 2), COORD_FRACTION_BITS));
        cmin = int'(round_half(coord(e[2], 0), COORD_FRACTION_BITS));
        cmax = int'(round_half(coord(e[2], 2), COORD_FRACTION_BITS));
        first_col = (pmin > cmin) ? pmin : cmin;
        end_col   = (pmax < cmax) ? pmax : cmax;
        cur_col   = first_col;
        for (int i = 0; i < 4; i++) begin
            off = (i < 2) ? first_col - pmin : first_col - cmin;
            slope[i] = edge_slope(e[i]);
            acc[i] = sat32(coord(e[i], 1) * (64'sd1 << (16 - COORD_FRACTION_BITS))
                           + longint'(slope[i]) * off);
        end
        color_q = d[271:256];
        shade_q = d[272];
    endtask

    // Next column span
    function automatic t_span next_span();
        t_span s;
        int    top, bot, x;
        logic  edge_col;
        s = '0;
        if (cur_col >= end_col) begin
            s.last_col = 1'b1;
            return s;
        end
        for (int i = 0; i < 4; i++) acc[i] = sat32(longint'(acc[i]) + slope[i]);
        x = cur_col;
        if (x >= 0 && x < SCREEN_COLUMNS) begin
            top = (acc[0] > acc[2]) ? acc[0] : acc[2];
            bot = (acc[1] < acc[3]) ? acc[1] : acc[3];
            edge_col = (x == first_col) || (x == end_col - 1);
            s.column_x    = 9'(x);
            s.first_y     = row_of(top);
            s.end_y       = row_of(bot);
            s.body_color  = (shade_q && edge_col) ? 16'd0 : color_q;
            s.first_color = shade_q ? 16'd0 : color_q;
            s.on_screen   = 1'b1;
        end
        s.last_col = (x + 1) >= end_col;
        cur_col = x + 1;
        return s;
    endfunction

    task automatic report(string what, logic [15:0] exp_v, logic [15:0] act_v);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        o_fail_count++;
    endtask

    // Watch both channels
    always @(posedge i_clk) begin
        t_span exp_s;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                acc[i] = 0;
                slope[i] = 0;
            end
            cur_col = 0; first_col = 0; end_col = 0;
            color_q = '0; shade_q = 1'b0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_START) load_primitive(i_s_tdata);
                else span_queue.push_back(next_span());
            end
            if (i_m_tvalid && i_m_tready) begin
                if (span_queue.size() == 0) begin
                    $display("%0t: span item with nothing expected, actual %0h",
                             $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    exp_s = span_queue.pop_front();
                    if (exp_s.column_x != i_m_tdata[8:0])
                        report("column_x", 16'(exp_s.column_x), 16'(i_m_tdata[8:0]));
                    if (exp_s.first_y != i_m_tdata[16:9])
                        report("span_first_y", 16'(exp_s.first_y), 16'(i_m_tdata[16:9]));
                    if (exp_s.end_y != i_m_tdata[24:17])
                        report("span_end_y", 16'(exp_s.end_y), 16'(i_m_tdata[24:17]));
                    if (exp_s.body_color != i_m_tdata[40:25])
                        report("body_color", exp_s.body_color, i_m_tdata[40:25]);
                    if (exp_s.first_color != i_m_tdata[56:41])
                        report("first_pixel_color", exp_s.first_color, i_m_tdata[56:41]);
                    if (i_m_tdata[63:57] != '0)
                        report("zero fill", 16'd0, 16'(i_m_tdata[63:57]));
                    if (exp_s.on_screen != i_m_tuser)
                        report("span_valid", 16'(exp_s.on_screen), 16'(i_m_tuser));
                    if (exp_s.last_col != i_m_tlast)
                        report("last_column", 16'(exp_s.last_col), 16'(i_m_tlast));
                end
            end
        end
        o_pending = span_queue.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top: stimulus, idling and verdict for the span rasterizer.
`timescale 1ns / 100ps

module tb;
    import cpsr_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    int                    fail_count;
    int                    pending;

    logic                  idle_on;
    logic                  took = 1'b0;
    int                    stall_left;

    clipped_parallelogram_span_rasterizer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast)
    );

    span_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Pack one edge from Q12.4 coordinates
    function automatic logic [63:0] pack_edge(int x0, int y0, int x1, int y1);
        return {16'(y1), 16'(x1), 16'(y0), 16'(x0)};
    endfunction

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // Send one item, with a random gap in front when idling is on
    task automatic send_item(logic cmd, logic [IN_DATA_W-1:0] d);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_start(logic [63:0] t, logic [63:0] b, logic [63:0] ct,
                              logic [63:0] cb, logic [15:0] color, logic shade);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[255:0] = {cb, ct, b, t};
        d[271:256] = color;
        d[272] = shade;
        send_item(CMD_START, d);
    endtask

    // Step payload is ignored, so fill it with noise
    task automatic send_step();
        logic [IN_DATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 8; i++) d[i*32 +: 32] = $urandom();
        d[272:256] = 17'($urandom());
        d[IN_DATA_W-1:273] = '0;
        send_item(CMD_STEP, d);
    endtask

    // Well-formed primitive: random wall with a random clip window near its columns
    task automatic random_primitive();
        int x0, x1, cx0, cx1, y0, y1, h, steps;
        x0  = rand_in(-60 * 16, 340 * 16);
        x1  = x0 + rand_in(0, 30 * 16);
        cx0 = x0 + rand_in(-10 * 16, 10 * 16);
        cx1 = x1 + rand_in(-10 * 16, 10 * 16);
        y0  = rand_in(-40 * 16, 250 * 16);
        y1  = rand_in(-40 * 16, 250 * 16);
        h   = rand_in(0, 200 * 16);
        send_start(pack_edge(x0, y0, x1, y1),
                   pack_edge(x0, y0 + h, x1, y1 + rand_in(0, 200 * 16)),
                   pack_edge(cx0, rand_in(-40 * 16, 120 * 16), cx1, rand_in(-40 * 16, 120 * 16)),
                   pack_edge(cx0, rand_in(100 * 16, 300 * 16), cx1, rand_in(100 * 16, 300 * 16)),
                   16'($urandom()), 1'($urandom()));
        steps = (x1 - x0) / 16 + rand_in(0, 2);
        for (int i = 0; i < steps; i++) send_step();
    endtask

    // Receiver stall, drawn per item
    always @(posedge i_clk) took <= m_tvalid && m_tready;

    always @(negedge i_clk) begin
        int s;
        s = stall_left;
        if (took) s = idle_on ? int'($urandom_range(0, 5)) : 0;
        if (s > 0) begin
            m_tready <= 1'b0;
            stall_left <= s - 1;
        end else begin
            m_tready <= 1'b1;
            stall_left <= 0;
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int items;
        s_tvalid = 1'b0;
        s_tuser = CMD_START;
        s_tdata = '0;
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Step right after reset: empty span
        send_step();
        // All-zero and all-ones fields
        send_start('0, '0, '0, '0, 16'h0000, 1'b0);
        send_step();
        send_start('1, '1, '1, '1, 16'hffff, 1'b1);
        send_step();
        // A vertical edge, off-screen columns on the left, shading on
        send_start(pack_edge(-3 * 16, 10 * 16, 4 * 16, 10 * 16),
                   pack_edge(-3 * 16, 50 * 16, -3 * 16, 90 * 16),
                   pack_edge(-5 * 16, 0, 8, 16'sh7ff0),
                   pack_edge(-5 * 16, 239 * 16, 10 * 16, 260 * 16), 16'h1234, 1'b1);
        repeat (9) send_step();
        // Right screen edge, steep slopes, shading off
        send_start(pack_edge(316 * 16 + 8, 16'sh8000, 322 * 16, 16'sh7fff),
                   pack_edge(316 * 16 + 8, 16'sh7fff, 322 * 16, 16'sh8000),
                   pack_edge(310 * 16, -8, 330 * 16, -8),
                   pack_edge(310 * 16, 240 * 16 + 8, 330 * 16, 240 * 16 + 8), 16'hffff, 1'b0);
        repeat (8) send_step();
        items = 25;

        // Random phase: mostly well-formed primitives, some noise
        while (items < 1900) begin
            if (($urandom_range(0, 15)) == 0) idle_on = ~idle_on;
            if (items > 900 && items < 960) begin
                // Hold off until every span has come back
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                items = 960;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_start({$urandom(), $urandom()}, {$urandom(), $urandom()},
                           {$urandom(), $urandom()}, {$urandom(), $urandom()},
                           16'($urandom()), 1'($urandom()));
                repeat (3) send_step();
                items += 4;
            end else begin
                random_primitive();
                items += 20;
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
